>>> rtl/umra_pkg.sv
// ----------------------------------------------------------------------------
// umra_pkg
// Shared types, constants and helper functions for the ultrasonic ranging
// block with median filtering and right-wall angle.
// ----------------------------------------------------------------------------
package umra_pkg;

  // Field widths
  localparam int DIST_W    = 10;
  localparam int SPACING_W = 8;
  localparam int ECHO_W    = 16;
  localparam int CHAN_W    = 2;
  localparam int SUM_W     = 11;
  localparam int ANGLE_W   = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int OUT_W     = 3 * DIST_W + SUM_W + ANGLE_W;

  // Default parameter values
  localparam int TARGET_RESET_CM_DEF = 15;
  localparam int FRONT_RESET_CM_DEF  = 100;
  localparam int CORDIC_STEPS_DEF    = 14;
  localparam int QUEUE_DEPTH_DEF     = 2;

  // echo / 58 as a reciprocal multiply, exact for every 16-bit echo width
  localparam int               DIV58_SHIFT = 22;
  localparam logic [16:0]      DIV58_MUL   = 17'd72316;
  localparam int               RAW_DIST_W  = 11;

  // CORDIC fixed point
  localparam int FRAC_BITS = 8;
  localparam int ATAN_LEN  = 20;
  localparam int ATAN_IW   = 5;
  localparam int ATAN_W    = 21;
  localparam int CX_W      = 21;
  localparam int CZ_W      = 24;
  localparam int ANGLE_MAX_CDEG = 9000;

  // Channel codes
  typedef enum logic [CHAN_W-1:0] {
    CH_FRONT      = 2'd0,
    CH_RIGHT_FRNT = 2'd1,
    CH_RIGHT_REAR = 2'd2,
    CH_UNUSED     = 2'd3
  } chan_t;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_VALID  = 3'd0,
    REG_MAX_VALID  = 3'd1,
    REG_ANGLE_MAX  = 3'd2,
    REG_SPACING    = 3'd3,
    REG_TIMEOUT    = 3'd4
  } reg_idx_t;

  // Configuration register set
  typedef struct packed {
    logic [DIST_W-1:0]    min_valid_cm;
    logic [DIST_W-1:0]    max_valid_cm;
    logic [DIST_W-1:0]    angle_max_cm;
    logic [SPACING_W-1:0] sensor_spacing_cm;
    logic [ECHO_W-1:0]    echo_timeout_us;
  } cfg_t;

  // Filtered distances handed from front end to back end
  typedef struct packed {
    logic [DIST_W-1:0] rear;
    logic [DIST_W-1:0] rfront;
    logic [DIST_W-1:0] front;
  } snap_t;

  // Median of three
  function automatic logic [DIST_W-1:0] med3(input logic [DIST_W-1:0] a,
                                             input logic [DIST_W-1:0] b,
                                             input logic [DIST_W-1:0] c);
    logic [DIST_W-1:0] lo;
    logic [DIST_W-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      med3 = lo;
    end else if (c >= hi) begin
      med3 = hi;
    end else begin
      med3 = c;
    end
  endfunction

  // atan(2^-i) in centidegrees times 256, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_q8(input logic [ATAN_IW-1:0] i);
    case (i)
      5'd0:    atan_q8 = 21'd1152000;
      5'd1:    atan_q8 = 21'd680065;
      5'd2:    atan_q8 = 21'd359328;
      5'd3:    atan_q8 = 21'd182400;
      5'd4:    atan_q8 = 21'd91554;
      5'd5:    atan_q8 = 21'd45822;
      5'd6:    atan_q8 = 21'd22916;
      5'd7:    atan_q8 = 21'd11459;
      5'd8:    atan_q8 = 21'd5730;
      5'd9:    atan_q8 = 21'd2865;
      5'd10:   atan_q8 = 21'd1432;
      5'd11:   atan_q8 = 21'd716;
      5'd12:   atan_q8 = 21'd358;
      5'd13:   atan_q8 = 21'd179;
      5'd14:   atan_q8 = 21'd90;
      5'd15:   atan_q8 = 21'd45;
      5'd16:   atan_q8 = 21'd22;
      5'd17:   atan_q8 = 21'd11;
      5'd18:   atan_q8 = 21'd6;
      5'd19:   atan_q8 = 21'd3;
      default: atan_q8 = 21'd0;
    endcase
  endfunction

endpackage

>>> rtl/umra_front.sv
// ----------------------------------------------------------------------------
// umra_front
// Accepts echo beats, converts width to distance, screens the reading and
// updates the per-channel median histories. Pushes the filtered distances.
// ----------------------------------------------------------------------------
module umra_front #(
  parameter int TARGET_RESET_CM = umra_pkg::TARGET_RESET_CM_DEF,
  parameter int FRONT_RESET_CM  = umra_pkg::FRONT_RESET_CM_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  umra_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [umra_pkg::CHAN_W-1:0]   in_chan,
  input  logic [umra_pkg::ECHO_W-1:0]   in_echo,
  output logic                          q_valid,
  input  logic                          q_ready,
  output umra_pkg::snap_t               q_data
);
  import umra_pkg::*;

  localparam int PROD_W = ECHO_W + $bits(DIV58_MUL);

  // Stage register: distance of the held beat
  logic                  a_vld;
  logic [CHAN_W-1:0]     a_ch;
  logic [RAW_DIST_W-1:0] a_dist;
  logic                  a_ok;

  logic [DIST_W-1:0] hist [3][3];
  logic [DIST_W-1:0] filt [3];

  logic [PROD_W-1:0]     prod;
  logic [RAW_DIST_W-1:0] raw_dist;
  logic                  echo_ok;
  logic                  push;
  logic                  take;
  logic [DIST_W-1:0]     dist10;
  logic [DIST_W-1:0]     h0;
  logic [DIST_W-1:0]     h1;
  logic [DIST_W-1:0]     med;
  logic [1:0]            row;
  logic                  row_ok;

  // Convert width to centimetres
  assign prod     = PROD_W'(in_echo) * PROD_W'(DIV58_MUL);
  assign raw_dist = prod[DIV58_SHIFT +: RAW_DIST_W];
  assign echo_ok  = (in_echo != '0) && (in_echo <= cfg.echo_timeout_us);

  assign push     = a_vld && q_ready;
  assign in_ready = !a_vld || q_ready;
  assign q_valid  = a_vld;

  // Pick the history row of the held channel
  always_comb begin
    row    = 2'd0;
    row_ok = 1'b1;
    case (a_ch)
      CH_FRONT:      row = 2'd0;
      CH_RIGHT_FRNT: row = 2'd1;
      CH_RIGHT_REAR: row = 2'd2;
      default:       row_ok = 1'b0;
    endcase
  end

  assign dist10 = a_dist[DIST_W-1:0];
  assign h0     = hist[row][0];
  assign h1     = hist[row][1];
  assign med    = med3(dist10, h0, h1);
  assign take   = a_ok && row_ok && (a_dist != '0)
                  && (a_dist >= RAW_DIST_W'(cfg.min_valid_cm))
                  && (a_dist <= RAW_DIST_W'(cfg.max_valid_cm));

  // Filtered distances after this beat
  always_comb begin
    q_data.front  = (take && row == 2'd0) ? med : filt[0];
    q_data.rfront = (take && row == 2'd1) ? med : filt[1];
    q_data.rear   = (take && row == 2'd2) ? med : filt[2];
  end

  // Hold the stage, shift histories on an accepted reading
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 3; k++) begin
          hist[c][k] <= (c == 0) ? DIST_W'(FRONT_RESET_CM) : DIST_W'(TARGET_RESET_CM);
        end
        filt[c] <= (c == 0) ? DIST_W'(FRONT_RESET_CM) : DIST_W'(TARGET_RESET_CM);
      end
    end else begin
      if (push && take) begin
        hist[row][2] <= h1;
        hist[row][1] <= h0;
        hist[row][0] <= dist10;
        filt[row]    <= med;
      end
      if (in_ready) begin
        a_vld  <= in_valid;
        a_ch   <= in_chan;
        a_dist <= raw_dist;
        a_ok   <= echo_ok;
      end
    end
  end

endmodule

>>> rtl/umra_queue.sv
// ----------------------------------------------------------------------------
// umra_queue
// Short first-in first-out queue of filtered distance snapshots between the
// front end and the angle back end.
// ----------------------------------------------------------------------------
module umra_queue #(
  parameter int DEPTH = umra_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  umra_pkg::snap_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output umra_pkg::snap_t rd_data
);
  import umra_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  snap_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          wr_en;
  logic          rd_en;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  // Store entries
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/umra_back.sv
// ----------------------------------------------------------------------------
// umra_back
// Pops a distance snapshot, runs the iterative vectoring CORDIC for the wall
// angle and loads the result into the output register.
// ----------------------------------------------------------------------------
module umra_back #(
  parameter int CORDIC_STEPS = umra_pkg::CORDIC_STEPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  umra_pkg::cfg_t               cfg,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  umra_pkg::snap_t              q_data,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [umra_pkg::OUT_W-1:0]   m_tdata,
  output logic [0:0]                   m_tuser
);
  import umra_pkg::*;

  localparam int STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_t;

  state_t             state;
  snap_t              cur;
  logic               neg;
  logic signed [CX_W-1:0] x;
  logic signed [CX_W-1:0] y;
  logic signed [CZ_W-1:0] z;
  logic [ATAN_IW-1:0] iter;

  logic signed [DIST_W:0]   diff;
  logic [DIST_W-1:0]        mag;
  logic signed [CX_W-1:0]   xs;
  logic signed [CX_W-1:0]   ys;
  logic signed [CZ_W-1:0]   at;
  logic signed [CZ_W-1:0]   zr;
  logic [ANGLE_W-1:0]       r;
  logic [ANGLE_W-1:0]       ang;
  logic                     fv;
  logic                     rv;
  logic                     ok;
  logic [SUM_W-1:0]         sum;
  logic                     out_free;

  // Load values for a new snapshot
  assign diff = $signed({1'b0, q_data.rear}) - $signed({1'b0, q_data.rfront});
  assign mag  = diff[DIST_W] ? DIST_W'(-diff) : diff[DIST_W-1:0];

  // One CORDIC micro-rotation
  assign xs = x >>> iter;
  assign ys = y >>> iter;
  assign at = CZ_W'(atan_q8(iter));

  // Round, saturate and sign the angle
  assign zr = (z + CZ_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
  always_comb begin
    if (zr < 0) begin
      r = '0;
    end else if (zr > CZ_W'(ANGLE_MAX_CDEG)) begin
      r = ANGLE_W'(ANGLE_MAX_CDEG);
    end else begin
      r = zr[ANGLE_W-1:0];
    end
  end

  assign fv  = (cur.rfront >= cfg.min_valid_cm) && (cur.rfront <= cfg.angle_max_cm);
  assign rv  = (cur.rear >= cfg.min_valid_cm) && (cur.rear <= cfg.angle_max_cm);
  assign ok  = fv && rv;
  assign ang = (!ok || cur.rear == cur.rfront) ? '0 : (neg ? -r : r);
  assign sum = SUM_W'(cur.rfront) + SUM_W'(cur.rear);

  assign out_free = !m_tvalid || m_tready;
  assign q_ready  = (state == S_IDLE);

  // Sequence the iterations and hold the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready && state != S_HOLD) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_data;
            neg   <= diff[DIST_W];
            x     <= CX_W'({cfg.sensor_spacing_cm, FRAC_BITS'(0)});
            y     <= CX_W'({mag, FRAC_BITS'(0)});
            z     <= '0;
            iter  <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (y > 0) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + at;
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - at;
          end
          iter <= iter + 1'b1;
          if (iter == ATAN_IW'(STEPS - 1)) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= {ang, sum, cur.rear, cur.rfront, cur.front};
            m_tuser[0] <= ok;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Iteration counter stays within the table
  a_iter_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (iter < ATAN_IW'(STEPS)))
    else $error("CORDIC iteration counter out of range");

  // A new result beat only comes out of the hold state
  a_out_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_HOLD))
    else $error("result beat raised outside hold state");

  // Angle is zero whenever the window flag is clear
  a_angle_masked: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[OUT_W-1 -: ANGLE_W] == '0))
    else $error("angle given without valid flag");

  // Angle magnitude saturates at ninety degrees
  a_angle_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD) |-> (r <= ANGLE_W'(ANGLE_MAX_CDEG)))
    else $error("angle magnitude above saturation limit");

endmodule

>>> rtl/ultrasonic_median_range_angle.sv
// ----------------------------------------------------------------------------
// ultrasonic_median_range_angle
// Echo widths in, median-filtered distances and right-wall angle out.
// ----------------------------------------------------------------------------
// Each echo beat is converted to centimetres (width / 58), screened against
// the timeout and the distance window, and pushed into its channel's
// three-deep median history; every beat gives one result beat carrying all
// three filtered distances, the right-side sum in centimetres and the
// wall angle in centidegrees with its valid flag in tuser. The front end
// takes a beat every cycle unless the queue holds it back, and hands
// snapshots through a two-entry queue to the angle unit, a single iterative
// CORDIC that finishes one snapshot before it takes the next (steps above
// 20 count as 20); that unit sets the sustained rate. The history state
// resets directly, there is no clearing pass. Configuration writes are
// always accepted and should be made only while no item is in flight.
// ----------------------------------------------------------------------------
module ultrasonic_median_range_angle #(
  parameter int TARGET_RESET_CM = umra_pkg::TARGET_RESET_CM_DEF,
  parameter int FRONT_RESET_CM  = umra_pkg::FRONT_RESET_CM_DEF,
  parameter int CORDIC_STEPS    = umra_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Echo input
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [15:0]                      s_tdata,    // [15:0] echo_us
  input  logic [1:0]                       s_tuser,    // [1:0] channel
  // Result output
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [9:0] front_cm, [19:10] right_front_cm, [29:20] right_rear_cm,
  // [40:30] right_sum_cm, [55:41] wall_angle_cdeg
  output logic [umra_pkg::OUT_W-1:0]       m_tdata,
  output logic [0:0]                       m_tuser,    // [0] angle_valid
  // Configuration write
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [umra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [umra_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import umra_pkg::*;

  cfg_t  cfg;
  logic  fq_valid;
  logic  fq_ready;
  snap_t fq_data;
  logic  qb_valid;
  logic  qb_ready;
  snap_t qb_data;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_valid_cm      <= DIST_W'(2);
      cfg.max_valid_cm      <= DIST_W'(400);
      cfg.angle_max_cm      <= DIST_W'(50);
      cfg.sensor_spacing_cm <= SPACING_W'(15);
      cfg.echo_timeout_us   <= ECHO_W'(30000);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_VALID: cfg.min_valid_cm      <= cfg_data[DIST_W-1:0];
        REG_MAX_VALID: cfg.max_valid_cm      <= cfg_data[DIST_W-1:0];
        REG_ANGLE_MAX: cfg.angle_max_cm      <= cfg_data[DIST_W-1:0];
        REG_SPACING:   cfg.sensor_spacing_cm <= cfg_data[SPACING_W-1:0];
        REG_TIMEOUT:   cfg.echo_timeout_us   <= cfg_data[ECHO_W-1:0];
        default:       cfg <= cfg;
      endcase
    end
  end

  umra_front #(
    .TARGET_RESET_CM (TARGET_RESET_CM),
    .FRONT_RESET_CM  (FRONT_RESET_CM)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_chan  (s_tuser),
    .in_echo  (s_tdata),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  umra_queue #(
    .DEPTH (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  umra_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (qb_valid),
    .q_ready  (qb_ready),
    .q_data   (qb_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
